// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the matrix multiply block.
// Define NO_ASSERTIONS to compile the checks out; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/mmul_pkg.sv =====
// Types, constants and helpers for the integer matrix multiply block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package mmul_pkg;

  localparam int DIM_DEF = 8;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W   = 3;
  localparam int OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // last loop index for a dimension register: zero counts as one,
  // anything above ext_max counts as ext_max
  function automatic logic [POS_W-1:0] dim_last(input logic [CFG_W-1:0] v,
                                                input int ext_max);
    logic [POS_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > ext_max) begin
      res = POS_W'(ext_max - 1);
    end else begin
      res = POS_W'(v - 1'b1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mmul_if.sv =====
// Valid/ready channel interfaces for the matrix multiply block.
// Depends on mmul_pkg for field widths.
`default_nettype none

interface mmul_in_if;
  import mmul_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         elem_row;
  logic [POS_W-1:0]         elem_col;
  logic signed [DATA_W-1:0] elem_value;

  modport source (output valid, opcode, elem_row, elem_col, elem_value, input ready);
  modport sink   (input valid, opcode, elem_row, elem_col, elem_value, output ready);
endinterface

interface mmul_out_if;
  import mmul_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         out_row;
  logic [POS_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/integer_matrix_multiply_top.sv =====
// Integer matrix multiply: element stores for A and B plus one shared MAC.
// Depends on mmul_pkg, mmul_if.sv and assert_macros.svh.
//
// Usage
//   cfg_*  : write rows_a, inner_dim, cols_b (index 0..2) while the block is idle.
//   in_ch  : write-A, write-B and compute items. An element whose row or
//            column is DIM or more is dropped.
//   out_ch : product elements in row-major order, out_last on the final one.
// Sequencing
//   A compute item starts a run of rows_a*cols_b results. For each result, the
//   two store ports are read inner_dim times to feed the single
//   multiply-accumulate, the read and multiply pipeline registers then drain,
//   and the sum is loaded into the output register. The input is not ready
//   during a run; it is ready again in the cycle after the last result loads.
// Stalls
//   The output register frees the MAC to work on the next element while a
//   result waits; if that one is done before the register empties, the run
//   holds until the receiver takes the transfer.
// Reset
//   Dimensions return to 1, control clears; store contents are undefined
//   until written.
`default_nettype none

module integer_matrix_multiply_top #(
  parameter int DIM = mmul_pkg::DIM_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mmul_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mmul_pkg::CFG_W-1:0]     cfg_data,
  mmul_in_if.sink                             in_ch,
  mmul_out_if.source                          out_ch
);
  import mmul_pkg::*;

  localparam int EXT_MAX = (DIM < 8) ? DIM : 8;
  localparam int DEPTH   = DIM * DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [CFG_W-1:0] rows_a_r, inner_dim_r, cols_b_r;

  // sequencer
  state_t           state_r, state_nxt;
  logic [POS_W-1:0] nr_m1_r, nk_m1_r, nc_m1_r;
  logic [POS_W-1:0] i_r, j_r, k_r;
  logic             rd_en, out_load, in_rdy, run_last, out_free;
  logic             in_xfer, start_run;

  // datapath
  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];
  logic [DATA_W-1:0] a_rd_r, b_rd_r, prod_r, acc_r;
  logic              v1_r, v2_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic              wr_ok, wr_a, wr_b;

  // output register
  logic                     out_valid_r, out_last_r;
  logic [POS_W-1:0]         out_row_r, out_col_r;
  logic [DATA_W-1:0]        out_value_r;

  assign in_xfer   = in_ch.valid && in_rdy;
  assign start_run = in_xfer && (in_ch.opcode == OP_COMPUTE);
  assign wr_ok     = (int'(in_ch.elem_row) < DIM) && (int'(in_ch.elem_col) < DIM);
  assign wr_a      = in_xfer && wr_ok && (in_ch.opcode == OP_WR_A);
  assign wr_b      = in_xfer && wr_ok && (in_ch.opcode == OP_WR_B);
  assign wr_addr   = ADDR_W'(int'(in_ch.elem_row) * DIM + int'(in_ch.elem_col));
  assign rd_addr_a = ADDR_W'(int'(i_r) * DIM + int'(k_r));
  assign rd_addr_b = ADDR_W'(int'(k_r) * DIM + int'(j_r));

  assign run_last = (i_r == nr_m1_r) && (j_r == nc_m1_r);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    in_rdy    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid && (in_ch.opcode == OP_COMPUTE)) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        rd_en = 1'b1;
        if (k_r == nk_m1_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // sum is final once both pipeline stages are empty
        if (!v1_r && !v2_r && out_free) begin
          out_load  = 1'b1;
          state_nxt = run_last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_a_r    <= CFG_W'(1);
      inner_dim_r <= CFG_W'(1);
      cols_b_r    <= CFG_W'(1);
      nr_m1_r     <= '0;
      nk_m1_r     <= '0;
      nc_m1_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r;

      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS_A:    rows_a_r    <= cfg_data;
          CFG_INNER_DIM: inner_dim_r <= cfg_data;
          CFG_COLS_B:    cols_b_r    <= cfg_data;
          default: ;
        endcase
      end

      if (start_run) begin
        nr_m1_r <= dim_last(rows_a_r, EXT_MAX);
        nk_m1_r <= dim_last(inner_dim_r, EXT_MAX);
        nc_m1_r <= dim_last(cols_b_r, EXT_MAX);
        i_r     <= '0;
        j_r     <= '0;
        k_r     <= '0;
        acc_r   <= '0;
      end

      if (rd_en) k_r <= (k_r == nk_m1_r) ? '0 : k_r + 1'b1;
      if (v2_r)  acc_r <= acc_r + prod_r;

      if (out_load) begin
        acc_r <= '0;
        if (j_r == nc_m1_r) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // element stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_a) mem_a[wr_addr] <= in_ch.elem_value;
    if (rd_en) a_rd_r <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) mem_b[wr_addr] <= in_ch.elem_value;
    if (rd_en) b_rd_r <= mem_b[rd_addr_b];
  end

  // low half of the product is the same signed or unsigned
  always_ff @(posedge clk) begin
    if (v1_r) prod_r <= a_rd_r * b_rd_r;
    if (out_load) begin
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_value_r <= acc_r;
      out_last_r  <= run_last;
    end
  end

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.out_last  = out_last_r;

`include "assert_macros.svh"

  `ASSERT_SAME(a_idx_bound, state_r == ST_ISSUE, (k_r <= nk_m1_r) && (i_r <= nr_m1_r) && (j_r <= nc_m1_r), "loop index beyond dimension")
  `ASSERT_SAME(a_pipe_empty_idle, state_r == ST_IDLE, !v1_r && !v2_r, "MAC pipeline busy while idle")
  `ASSERT_NEXT(a_last_ends_run, out_load && run_last, state_r == ST_IDLE && out_valid_r && out_last_r, "run did not end on last element")
  `ASSERT_NEXT(a_load_holds, out_load, out_valid_r && !v1_r && !v2_r, "result loaded with pipeline busy")

endmodule

`default_nettype wire
